// ===== hw/rtl/grdc_pkg.sv =====
package grdc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAP_BITS = 6;
	localparam int ADDR_BITS = 2 * MAP_BITS;
	localparam int MAP_DEPTH = 1 << ADDR_BITS;
	localparam int CELL_BITS = 5;
	localparam int DIV_BITS = 33;
	localparam int DIV_CNT_BITS = 6;
	localparam int STEP_CNT_BITS = 8;
	localparam logic [STEP_CNT_BITS-1:0] MAX_STEPS = 8'd130;
	localparam logic [11:0] SCREEN_WIDTH_RESET = 12'd640;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CAST = 1'b1;

	localparam logic [1:0] TILE_WALL = 2'd1;
	localparam logic [1:0] TILE_DOOR = 2'd2;
	localparam logic [2:0] DOOR_OPEN_FRAME = 3'd3;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAM,
		ST_MULX,
		ST_MULY,
		ST_RDY,
		ST_DIVX,
		ST_DIVY,
		ST_MSX,
		ST_MSY,
		ST_SETY,
		ST_STEP,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] tile;
		logic [2:0] frame;
	} cell_t;

endpackage

// ===== hw/rtl/grid_ray_dda_caster_unit.sv =====
// Grid ray caster. Two channels with valid/stall handshakes and one config write port.
// Input transaction: func 0 writes tile_code and door_frame for cell (cell_x, cell_y)
// and produces no result; the block is ready again in the next cycle. func 1 casts
// the ray for one screen column from the player position, direction and camera plane.
// Output transaction: one per cast, with the hit cell, side, final side distances,
// hit_door, and left_map when the walk stepped off the map.
// A cast runs a setup, then walks the grid step by step, up to 130 steps. The setup
// uses the shared restoring divider (camera x and two reciprocals) and the shared
// multiplier; each step waits on the registered read of the map memory. in_stall
// stays high while a cast is in progress.
// A finished result sits in the output register; the block accepts the next
// transaction while it waits. If the receiver stalls and a second cast finishes, that
// cast holds until the output register is free.
// cfg_we writes screen_width (0 is treated as 1); write it only while idle.
// Reset (arst_n low) sets screen_width to 640 and empties the pipeline. The map memory
// is not cleared: a cell must be written before a ray reads it.
module grid_ray_dda_caster_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [11:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_y,
	input  logic [1:0]         tile_code,
	input  logic [2:0]         door_frame,
	input  logic [11:0]        column,
	input  logic [21:0]        pos_x,
	input  logic [21:0]        pos_y,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic signed [17:0] plane_x,
	input  logic signed [17:0] plane_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        ray_column,
	output logic [5:0]         hit_x,
	output logic [5:0]         hit_y,
	output logic               hit_side,
	output logic [31:0]        final_side_x,
	output logic [31:0]        final_side_y,
	output logic               hit_door,
	output logic               left_map
);
	import grdc_pkg::*;

	state_t state_q, state_d;

	logic [11:0] width_q;
	logic [11:0] column_q;
	logic [21:0] px_q, py_q;
	logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic signed [31:0] cam_q, rdx_q, rdy_q;
	logic [31:0] dx_q, dy_q, sx_q, sy_q;
	logic [MAP_BITS-1:0] mx_q, my_q;
	logic side_q, door_q, left_q;
	logic [STEP_CNT_BITS-1:0] cnt_q;
	logic signed [50:0] prod_q;

	logic out_valid_q;
	logic [11:0] ray_column_q;
	logic [5:0] hit_x_q, hit_y_q;
	logic hit_side_q, hit_door_q, left_map_q;
	logic [31:0] final_side_x_q, final_side_y_q;

	logic in_acc, cast_acc, write_acc;
	logic out_free;

	logic div_start, div_done;
	logic [DIV_BITS-1:0] div_num, div_quot;
	logic [31:0] div_den;
	logic [31:0] div_res;

	logic signed [17:0] mul_a;
	logic signed [32:0] mul_b;

	logic [31:0] abs_rdx, abs_rdy;
	logic [16:0] frac_x, frac_y;
	logic signed [34:0] ray_sum;
	logic signed [31:0] ray_sat;
	logic [31:0] side_sat;

	logic take_x;
	logic [32:0] step_sum;
	logic [31:0] step_sat;
	logic [MAP_BITS:0] nx, ny;
	logic off_map;
	logic blocked, is_door;

	logic mem_re;
	logic [ADDR_BITS-1:0] mem_raddr;
	cell_t mem_wdata, mem_rdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign cast_acc = in_acc && (func == FUNC_CAST);
	assign write_acc = in_acc && (func == FUNC_WRITE);
	assign out_free = !out_valid_q || !out_stall;

	assign abs_rdx = rdx_q[31] ? (~rdx_q + 32'd1) : rdx_q;
	assign abs_rdy = rdy_q[31] ? (~rdy_q + 32'd1) : rdy_q;
	assign frac_x = rdx_q[31] ? {1'b0, px_q[FRAC_BITS-1:0]}
	                          : (17'h10000 - {1'b0, px_q[FRAC_BITS-1:0]});
	assign frac_y = rdy_q[31] ? {1'b0, py_q[FRAC_BITS-1:0]}
	                          : (17'h10000 - {1'b0, py_q[FRAC_BITS-1:0]});

	// Floor of the product over 2^F is an arithmetic shift; the sum saturates to 32 bits.
	always_comb begin
		ray_sum = 35'(prod_q[50:FRAC_BITS]) + 35'(state_q == ST_MULY ? dir_x_q : dir_y_q);
		if (ray_sum > 35'sh0_7FFF_FFFF) begin
			ray_sat = 32'sh7FFF_FFFF;
		end else if (ray_sum < -35'sh0_8000_0000) begin
			ray_sat = 32'sh8000_0000;
		end else begin
			ray_sat = ray_sum[31:0];
		end
	end

	assign side_sat = prod_q[48] ? SAT32 : prod_q[47:FRAC_BITS];
	assign div_res = div_quot[DIV_BITS-1] ? SAT32 : div_quot[31:0];

	// Ties cross the y boundary.
	assign take_x = (sx_q < sy_q);
	assign step_sum = take_x ? ({1'b0, sx_q} + {1'b0, dx_q}) : ({1'b0, sy_q} + {1'b0, dy_q});
	assign step_sat = step_sum[32] ? SAT32 : step_sum[31:0];
	always_comb begin
		nx = {1'b0, mx_q};
		ny = {1'b0, my_q};
		if (take_x) begin
			nx = rdx_q[31] ? ({1'b0, mx_q} - 1'b1) : ({1'b0, mx_q} + 1'b1);
		end else begin
			ny = rdy_q[31] ? ({1'b0, my_q} - 1'b1) : ({1'b0, my_q} + 1'b1);
		end
	end
	assign off_map = nx[MAP_BITS] || ny[MAP_BITS];

	assign is_door = (mem_rdata.tile == TILE_DOOR) && (mem_rdata.frame < DOOR_OPEN_FRAME);
	assign blocked = (mem_rdata.tile == TILE_WALL) || is_door;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (cast_acc) state_d = ST_CAM;
			ST_CAM:   if (div_done) state_d = ST_MULX;
			ST_MULX:  state_d = ST_MULY;
			ST_MULY:  state_d = ST_RDY;
			ST_RDY:   state_d = ST_DIVX;
			ST_DIVX:  if (div_done) state_d = ST_DIVY;
			ST_DIVY:  if (div_done) state_d = ST_MSX;
			ST_MSX:   state_d = ST_MSY;
			ST_MSY:   state_d = ST_SETY;
			ST_SETY:  state_d = ST_STEP;
			ST_STEP:  state_d = off_map ? ST_DONE : ST_CHECK;
			ST_CHECK: begin
				if (blocked || cnt_q == MAX_STEPS) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num = {DIV_BITS{1'b0}};
		div_num[32] = 1'b1;
		div_den = abs_rdx;
		mul_a = '0;
		mul_b = '0;
		mem_re = 1'b0;
		case (state_q)
			ST_IDLE: begin
				div_start = cast_acc;
				div_num = {4'b0, column, 1'b0, 16'b0};
				div_den = (width_q == 12'd0) ? 32'd1 : {20'b0, width_q};
			end
			ST_MULX: begin
				mul_a = plane_x_q;
				mul_b = 33'(cam_q);
			end
			ST_MULY: begin
				mul_a = plane_y_q;
				mul_b = 33'(cam_q);
			end
			ST_RDY: div_start = 1'b1;
			ST_DIVX: begin
				div_start = div_done;
				div_den = abs_rdy;
			end
			ST_MSX: begin
				mul_a = {1'b0, frac_x};
				mul_b = {1'b0, dx_q};
			end
			ST_MSY: begin
				mul_a = {1'b0, frac_y};
				mul_b = {1'b0, dy_q};
			end
			ST_STEP: mem_re = !off_map;
			default: ;
		endcase
	end

	assign mem_raddr = {ny[MAP_BITS-1:0], nx[MAP_BITS-1:0]};
	assign mem_wdata = '{tile: tile_code, frame: door_frame};

	grdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	grdc_map u_map (
		.clk   (clk),
		.we    (write_acc),
		.waddr ({cell_y, cell_x}),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= SCREEN_WIDTH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				width_q <= cfg_data;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (cast_acc) begin
					column_q <= column;
					px_q <= pos_x;
					py_q <= pos_y;
					dir_x_q <= dir_x;
					dir_y_q <= dir_y;
					plane_x_q <= plane_x;
					plane_y_q <= plane_y;
					mx_q <= pos_x[FRAC_BITS +: MAP_BITS];
					my_q <= pos_y[FRAC_BITS +: MAP_BITS];
					side_q <= 1'b0;
					door_q <= 1'b0;
					left_q <= 1'b0;
					cnt_q <= '0;
				end
			end
			ST_CAM:   if (div_done) cam_q <= div_quot[31:0] - 32'sh0001_0000;
			ST_MULY:  rdx_q <= ray_sat;
			ST_RDY:   rdy_q <= ray_sat;
			ST_DIVX:  if (div_done) dx_q <= div_res;
			ST_DIVY:  if (div_done) dy_q <= div_res;
			ST_MSY:   sx_q <= side_sat;
			ST_SETY:  sy_q <= side_sat;
			ST_STEP: begin
				cnt_q <= cnt_q + 1'b1;
				side_q <= !take_x;
				if (take_x) begin
					sx_q <= step_sat;
				end else begin
					sy_q <= step_sat;
				end
				if (off_map) begin
					left_q <= 1'b1;
				end else begin
					mx_q <= nx[MAP_BITS-1:0];
					my_q <= ny[MAP_BITS-1:0];
				end
			end
			ST_CHECK: door_q <= is_door;
			ST_DONE: begin
				if (out_free) begin
					ray_column_q <= column_q;
					hit_x_q <= mx_q;
					hit_y_q <= my_q;
					hit_side_q <= side_q;
					final_side_x_q <= sx_q;
					final_side_y_q <= sy_q;
					hit_door_q <= door_q;
					left_map_q <= left_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign ray_column = ray_column_q;
	assign hit_x = hit_x_q;
	assign hit_y = hit_y_q;
	assign hit_side = hit_side_q;
	assign final_side_x = final_side_x_q;
	assign final_side_y = final_side_y_q;
	assign hit_door = hit_door_q;
	assign left_map = left_map_q;

endmodule

// ===== hw/rtl/grdc_div.sv =====
module grdc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [grdc_pkg::DIV_BITS-1:0]  num,
	input  logic [31:0]                    den,
	output logic                           done,
	output logic [grdc_pkg::DIV_BITS-1:0]  quot
);
	import grdc_pkg::*;

	logic [DIV_BITS-1:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic qbit;

	assign trial = {rem_q, num_q[DIV_BITS-1]};
	assign diff = trial - {1'b0, den_q};
	assign qbit = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_BITS'(DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient bits shift into the numerator register as it drains.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[31:0] : trial[31:0];
			num_q <= {num_q[DIV_BITS-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== hw/rtl/grdc_map.sv =====
module grdc_map (
	input  logic                            clk,
	input  logic                            we,
	input  logic [grdc_pkg::ADDR_BITS-1:0]  waddr,
	input  grdc_pkg::cell_t                 wdata,
	input  logic                            re,
	input  logic [grdc_pkg::ADDR_BITS-1:0]  raddr,
	output grdc_pkg::cell_t                 rdata
);
	import grdc_pkg::*;

	cell_t mem [MAP_DEPTH];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/grdc_checker.sv =====
module grdc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       func,
	input logic       out_valid,
	input logic       out_stall,
	input logic [11:0] ray_column,
	input logic       hit_door,
	input logic       left_map
);
	import grdc_pkg::*;

	// A cast transaction leaves the block busy once it is accepted.
	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_CAST |=> in_stall)
		else $error("block ready right after a cast");

	// A map write leaves the block ready in the next cycle.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_WRITE |=> !in_stall)
		else $error("block busy after a map write");

	// A new result appears only as a cast finishes.
	a_result_from_cast: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a cast in progress");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit_door && left_map))
		else $error("door hit and map exit flagged together");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ray_column))
		else $error("stalled result changed");

endmodule

bind grid_ray_dda_caster_unit grdc_checker u_grdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.func       (func),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.ray_column (ray_column),
	.hit_door   (hit_door),
	.left_map   (left_map)
);
